FILE: design/llf_pkg.sv
package llf_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned TICK_W     = 64;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [CFG_ADDR_W-1:0] REG_SINCE_TICKS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_UNTIL_TICKS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_ENABLES = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PRIO_LIMIT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_UNIT_LENGTH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_UNIT_TEXT    = 3'd5;

    typedef struct packed {
        logic [TICK_W-1:0] since_ticks;
        logic [TICK_W-1:0] until_ticks;
        logic [1:0]        time_enables;
        logic signed [8:0] prio_limit;
        logic [3:0]        unit_length;
        logic [63:0]       unit_text;
    } t_cfg;

    typedef struct packed {
        logic              prio_found;
        logic signed [8:0] prio_res;
        logic [TICK_W-1:0] ticks;
        logic              tag_ok;
    } t_line_res;

endpackage

FILE: design/llf_intf.sv
interface llf_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       line_end;

    modport source (output valid, output line_byte, output line_end, input ready);
    modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

interface llf_res_if;
    logic              valid;
    logic              ready;
    logic              keep;
    logic              priority_found;
    logic signed [8:0] priority_res;
    logic [63:0]       ticks;

    modport source (output valid, output keep, output priority_found,
                    output priority_res, output ticks, input ready);
    modport sink   (input valid, input keep, input priority_found,
                    input priority_res, input ticks, output ready);
endinterface

interface llf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [63:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: design/llf_cfg_regs.sv
module llf_cfg_regs (
    input  logic         i_clk,
    input  logic         i_rst_n,
    llf_cfg_if.sink      i_cfg,
    output llf_pkg::t_cfg o_cfg
);
    import llf_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.since_ticks  <= '0;
            r_cfg.until_ticks  <= '0;
            r_cfg.time_enables <= '0;
            r_cfg.prio_limit   <= 9'h1FF;
            r_cfg.unit_length  <= '0;
            r_cfg.unit_text    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                REG_SINCE_TICKS:  r_cfg.since_ticks  <= i_cfg.data;
                REG_UNTIL_TICKS:  r_cfg.until_ticks  <= i_cfg.data;
                REG_TIME_ENABLES: r_cfg.time_enables <= i_cfg.data[1:0];
                REG_PRIO_LIMIT:   r_cfg.prio_limit   <= i_cfg.data[8:0];
                REG_UNIT_LENGTH:  r_cfg.unit_length  <= i_cfg.data[3:0];
                REG_UNIT_TEXT:    r_cfg.unit_text    <= i_cfg.data;
                default: ;
            endcase
        end
    end
endmodule

FILE: design/llf_parser.sv
module llf_parser #(
    parameter int unsigned TAG_CHARS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    llf_line_if.sink          i_line,
    input  llf_pkg::t_cfg     i_cfg,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output llf_pkg::t_line_res o_res
);
    import llf_pkg::*;

    localparam int unsigned TCW = $clog2(TAG_CHARS + 2);
    localparam logic [TCW-1:0] TC_CHARS = TCW'(TAG_CHARS);

    // input register
    logic       r_a_valid;
    logic [7:0] r_a_byte;
    logic       r_a_end;

    // per-line state
    logic [1:0]        r_idx, n_idx;
    logic              r_angle, n_angle;
    logic [7:0]        r_prio_byte, n_prio_byte;
    logic              r_prio_valid, n_prio_valid;
    logic              r_bracket, n_bracket;
    logic              r_digits, n_digits;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic              r_close, n_close;
    logic              r_space, n_space;
    logic              r_colon, n_colon;
    logic [TCW-1:0]    r_tcnt, n_tcnt;
    logic              r_equal, n_equal;

    logic       r_s_valid;
    t_line_res  r_s, n_s;

    logic       snap_ready;
    logic       a_adv;
    logic [7:0] b;
    logic [7:0] want;
    logic [7:0] digit;

    assign snap_ready   = !r_s_valid || i_res_ready;
    assign a_adv        = r_a_valid && (!r_a_end || snap_ready);
    assign i_line.ready = !r_a_valid || a_adv;
    assign o_res_valid  = r_s_valid;
    assign o_res        = r_s;

    assign b     = r_a_byte;
    assign want  = i_cfg.unit_text[8*(3'(r_tcnt)) +: 8];
    assign digit = b - CH_ZERO;

    always_comb begin
        n_idx        = r_idx;
        n_angle      = r_angle;
        n_prio_byte  = r_prio_byte;
        n_prio_valid = r_prio_valid;
        n_bracket    = r_bracket;
        n_digits     = r_digits;
        n_tick       = r_tick;
        n_close      = r_close;
        n_space      = r_space;
        n_colon      = r_colon;
        n_tcnt       = r_tcnt;
        n_equal      = r_equal;

        // priority header
        case (r_idx)
            2'd0: n_angle = (b == CH_LT);
            2'd1: n_prio_byte = b;
            2'd2: n_prio_valid = r_angle && (b == CH_GT);
            default: ;
        endcase
        if (r_idx != 2'd3) begin
            n_idx = r_idx + 2'd1;
        end

        // bracketed ticks
        if (r_bracket && b == CH_RBR) begin
            n_close = 1'b1;
        end
        if (!r_bracket && b == CH_LBR) begin
            n_bracket = 1'b1;
            n_digits  = 1'b1;
            n_tick    = '0;
        end else if (r_digits) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                n_tick = (r_tick << 3) + (r_tick << 1) + TICK_W'(digit);
            end else begin
                n_digits = 1'b0;
            end
        end

        // tag
        if (!r_space) begin
            if (b == CH_SP) begin
                n_space = 1'b1;
            end
        end else if (!r_colon) begin
            if (b == CH_COLON) begin
                n_colon = 1'b1;
            end else begin
                if (4'(r_tcnt) < i_cfg.unit_length && r_tcnt < TC_CHARS && want != b) begin
                    n_equal = 1'b0;
                end
                if (r_tcnt < TC_CHARS + TCW'(1)) begin
                    n_tcnt = r_tcnt + TCW'(1);
                end
            end
        end

        n_s.prio_found = n_prio_valid;
        n_s.prio_res   = n_prio_valid ? ($signed({1'b0, n_prio_byte}) - 9'sd48) : 9'sd0;
        n_s.ticks      = n_close ? n_tick : '0;
        n_s.tag_ok     = (i_cfg.unit_length <= 4'(TAG_CHARS)) && n_colon
                         && (4'(n_tcnt) == i_cfg.unit_length) && n_equal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_line.ready) begin
            r_a_valid <= i_line.valid;
        end
        if (i_line.ready && i_line.valid) begin
            r_a_byte <= i_line.line_byte;
            r_a_end  <= i_line.line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (a_adv && r_a_end)) begin
            r_idx        <= '0;
            r_angle      <= 1'b0;
            r_prio_byte  <= '0;
            r_prio_valid <= 1'b0;
            r_bracket    <= 1'b0;
            r_digits     <= 1'b0;
            r_tick       <= '0;
            r_close      <= 1'b0;
            r_space      <= 1'b0;
            r_colon      <= 1'b0;
            r_tcnt       <= '0;
            r_equal      <= 1'b1;
        end else if (a_adv) begin
            r_idx        <= n_idx;
            r_angle      <= n_angle;
            r_prio_byte  <= n_prio_byte;
            r_prio_valid <= n_prio_valid;
            r_bracket    <= n_bracket;
            r_digits     <= n_digits;
            r_tick       <= n_tick;
            r_close      <= n_close;
            r_space      <= n_space;
            r_colon      <= n_colon;
            r_tcnt       <= n_tcnt;
            r_equal      <= n_equal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (snap_ready) begin
            r_s_valid <= a_adv && r_a_end;
        end
        if (snap_ready && a_adv && r_a_end) begin
            r_s <= n_s;
        end
    end
endmodule

FILE: design/llf_decide.sv
module llf_decide (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  llf_pkg::t_cfg      i_cfg,
    input  logic               i_res_valid,
    input  llf_pkg::t_line_res i_res,
    output logic               o_res_ready,
    llf_res_if.source          o_res
);
    import llf_pkg::*;

    logic              r_o_valid;
    logic              r_keep;
    logic              r_found;
    logic signed [8:0] r_prio;
    logic [TICK_W-1:0] r_ticks;

    logic n_keep;
    logic drop_prio, drop_since, drop_until, drop_tag;

    assign o_res_ready          = !r_o_valid || o_res.ready;
    assign o_res.valid          = r_o_valid;
    assign o_res.keep           = r_keep;
    assign o_res.priority_found = r_found;
    assign o_res.priority_res   = r_prio;
    assign o_res.ticks          = r_ticks;

    always_comb begin
        drop_prio  = !i_cfg.prio_limit[8] && i_res.prio_found && !i_res.prio_res[8]
                     && (i_res.prio_res > i_cfg.prio_limit);
        drop_since = i_cfg.time_enables[0] && (i_res.ticks < i_cfg.since_ticks);
        drop_until = i_cfg.time_enables[1] && (i_res.ticks > i_cfg.until_ticks);
        drop_tag   = (i_cfg.unit_length != 4'd0) && !i_res.tag_ok;
        n_keep     = !(drop_prio || drop_since || drop_until || drop_tag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_o_valid <= i_res_valid;
        end
        if (o_res_ready && i_res_valid) begin
            r_keep  <= n_keep;
            r_found <= i_res.prio_found;
            r_prio  <= i_res.prio_res;
            r_ticks <= i_res.ticks;
        end
    end
endmodule

FILE: design/log_line_filter.sv
// channel   dir  handshake     payload
// i_line    in   valid/ready   line_byte[7:0], line_end
// o_res     out  valid/ready   keep, priority_found, priority_res[8:0], ticks[63:0]
// i_cfg     in   valid/ready   addr[2:0], data[63:0]
//
// one byte per cycle unless a line-end byte waits on a full snapshot stage
// stages: input register, line parser with snapshot register, filter compare
// and output register
// synchronous active-low reset clears all line state and loads register defaults
// a stall on o_res backs up only when a line-end item meets a full snapshot stage
module log_line_filter #(
    parameter int unsigned TAG_CHARS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    llf_line_if.sink   i_line,
    llf_cfg_if.sink    i_cfg,
    llf_res_if.source  o_res
);
    import llf_pkg::*;

    t_cfg      cfg;
    t_line_res line_res;
    logic      line_res_valid;
    logic      line_res_ready;

    llf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    llf_parser #(
        .TAG_CHARS (TAG_CHARS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_line      (i_line),
        .i_cfg       (cfg),
        .i_res_ready (line_res_ready),
        .o_res_valid (line_res_valid),
        .o_res       (line_res)
    );

    llf_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_res_valid (line_res_valid),
        .i_res       (line_res),
        .o_res_ready (line_res_ready),
        .o_res       (o_res)
    );
endmodule
